// ===== rtl/wide_char_to_utf8_encoder_top_assert.svh =====
// assertion macros for the wide character to utf-8 encoder
// expects clk and rst_n in the scope of each use
`ifndef WIDE_CHAR_TO_UTF8_ENCODER_TOP_ASSERT_SVH
`define WIDE_CHAR_TO_UTF8_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define WCTU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds on the edge after the antecedent
`define WCTU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WCTU_ASSERT_ALWAYS(lbl, cond, msg)
`define WCTU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/wctu_pkg.sv =====
// shared types, constants and byte encoding functions for the utf-8 encoder
// no dependencies
package wctu_pkg;

    localparam int UNIT_W     = 21;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 2;
    localparam int HELD_W     = 10;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 2;

    localparam logic [PADDR_W-1:0] REG_ADDR_MODE = 2'd0;

    localparam logic [UNIT_W-1:0] HIGH_SURR_MIN = 21'h00D800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_MAX = 21'h00DBFF;
    localparam logic [UNIT_W-1:0] LOW_SURR_MIN  = 21'h00DC00;
    localparam logic [UNIT_W-1:0] LOW_SURR_MAX  = 21'h00DFFF;
    localparam logic [UNIT_W-1:0] CP_SUPP_BASE  = 21'h010000;
    localparam logic [UNIT_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [UNIT_W-1:0] CP_MAX_1BYTE  = 21'h00007F;
    localparam logic [UNIT_W-1:0] CP_MAX_2BYTE  = 21'h0007FF;
    localparam logic [UNIT_W-1:0] CP_MAX_3BYTE  = 21'h00FFFF;

    localparam logic [BYTE_W-1:0] LEAD_2BYTE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3BYTE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4BYTE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_BYTE  = 8'h80;

    // queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // encoding lengths, held as index of the final byte
    typedef enum logic [IDX_W-1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } len_t;

    // one classified transaction waiting for the back end
    typedef struct packed {
        logic [UNIT_W-1:0] cp;
        logic              err;
        len_t              last_idx;
    } q_entry_t;

    // configuration write towards the front end
    typedef struct packed {
        logic wr;
        logic mode;
    } cfg_wr_t;

    function automatic len_t enc_len(input logic [UNIT_W-1:0] cp);
        len_t len;
        if (cp <= CP_MAX_1BYTE)
            len = LEN_1;
        else if (cp <= CP_MAX_2BYTE)
            len = LEN_2;
        else if (cp <= CP_MAX_3BYTE)
            len = LEN_3;
        else
            len = LEN_4;
        return len;
    endfunction

    // continuation byte carrying six bits starting at group g from the bottom
    function automatic logic [BYTE_W-1:0] cont_byte(input logic [UNIT_W-1:0] cp,
                                                    input logic [1:0] g);
        logic [5:0] bits;
        case (g)
            2'd0:    bits = cp[5:0];
            2'd1:    bits = cp[11:6];
            2'd2:    bits = cp[17:12];
            default: bits = 6'd0;
        endcase
        return CONT_BYTE | {2'b00, bits};
    endfunction

    // byte idx of the encoding of cp with the given length
    function automatic logic [BYTE_W-1:0] enc_byte(input logic [UNIT_W-1:0] cp,
                                                   input len_t len,
                                                   input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        if (idx == 2'd0) begin
            case (len)
                LEN_1:   b = {1'b0, cp[6:0]};
                LEN_2:   b = LEAD_2BYTE | {3'b000, cp[10:6]};
                LEN_3:   b = LEAD_3BYTE | {4'b0000, cp[15:12]};
                LEN_4:   b = LEAD_4BYTE | {5'b00000, cp[20:18]};
                default: b = '0;
            endcase
        end
        else begin
            b = cont_byte(cp, IDX_W'(len) - idx);
        end
        return b;
    endfunction

endpackage

// ===== rtl/wctu_front.sv =====
// front end: takes code units, pairs surrogates in pair mode, classifies into queue entries
// depends on wctu_pkg
module wctu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wctu_pkg::cfg_wr_t            cfg,
    output logic                         pair_mode,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [wctu_pkg::UNIT_W-1:0]  code_unit,
    input  logic                         end_of_string,
    input  logic                         q_full,
    output logic                         q_push,
    output wctu_pkg::q_entry_t           q_data
);
    import wctu_pkg::*;

    logic              pair_mode_reg;
    logic              high_pending_reg, high_pending_next;
    logic [HELD_W-1:0] held_high_bits_reg, held_high_bits_next;

    logic              accept;
    logic              is_high, is_low;
    logic              has_result;
    logic              err;
    logic [UNIT_W-1:0] cp;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign pair_mode = pair_mode_reg;

    assign is_high = code_unit inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
    assign is_low  = code_unit inside {[LOW_SURR_MIN:LOW_SURR_MAX]};

    // classify the unit against the held surrogate
    always_comb
    begin
        has_result          = 1'b1;
        err                 = 1'b0;
        cp                  = code_unit;
        high_pending_next   = high_pending_reg;
        held_high_bits_next = held_high_bits_reg;
        if (pair_mode_reg) begin
            if (high_pending_reg) begin
                high_pending_next   = 1'b0;
                held_high_bits_next = '0;
                if (is_low)
                    cp = {1'b0, held_high_bits_reg, code_unit[9:0]} + CP_SUPP_BASE;
                else
                    err = 1'b1;
            end
            else if (is_high) begin
                if (end_of_string) begin
                    err = 1'b1;
                end
                else begin
                    has_result          = 1'b0;
                    high_pending_next   = 1'b1;
                    held_high_bits_next = code_unit[HELD_W-1:0];
                end
            end
            else if (is_low) begin
                err = 1'b1;
            end
        end
        if (cp > CP_MAX) begin
            err = 1'b1;
        end
        if (err) begin
            high_pending_next   = 1'b0;
            held_high_bits_next = '0;
        end
    end

    // queue entry
    always_comb
    begin
        q_push         = accept && has_result;
        q_data.cp      = cp;
        q_data.err     = err;
        q_data.last_idx = err ? LEN_1 : enc_len(cp);
    end

    // mode register and held surrogate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pair_mode_reg      <= 1'b1;
            high_pending_reg   <= 1'b0;
            held_high_bits_reg <= '0;
        end
        else if (cfg.wr) begin
            pair_mode_reg      <= cfg.mode;
            high_pending_reg   <= 1'b0;
            held_high_bits_reg <= '0;
        end
        else if (accept) begin
            high_pending_reg   <= high_pending_next;
            held_high_bits_reg <= held_high_bits_next;
        end
    end

`include "wide_char_to_utf8_encoder_top_assert.svh"

    `WCTU_ASSERT_NEXT(a_cfg_clears_hold, cfg.wr, !high_pending_reg, "hold survived mode write")
    `WCTU_ASSERT_ALWAYS(a_no_hold_utf32, !(high_pending_reg && !pair_mode_reg), "hold in utf-32 mode")

endmodule

// ===== rtl/wctu_queue.sv =====
// short queue between front and back ends
// depends on wctu_pkg
module wctu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  wctu_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output wctu_pkg::q_entry_t head_data
);
    import wctu_pkg::*;

    q_entry_t           mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

`include "wide_char_to_utf8_encoder_top_assert.svh"

    `WCTU_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full queue")
    `WCTU_ASSERT_ALWAYS(a_no_underflow, !(pop && !head_valid), "pop from empty queue")

endmodule

// ===== rtl/wctu_back.sv =====
// back end: expands queue entries into utf-8 bytes, one per cycle while out_ready is high
// depends on wctu_pkg
module wctu_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  wctu_pkg::q_entry_t           q_data,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wctu_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_byte,
    output logic                         error
);
    import wctu_pkg::*;

    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, byte_next;
    logic              last_byte_reg, last_next;
    logic              error_reg;
    logic              load;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;
    assign error     = error_reg;

    // next byte of the head entry
    assign load      = q_valid && (!out_valid_reg || out_ready);
    assign last_next = (idx_reg == q_data.last_idx);
    assign q_pop     = load && last_next;
    assign byte_next = q_data.err ? '0 : enc_byte(q_data.cp, q_data.last_idx, idx_reg);

    // output register and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_byte_reg  <= '0;
            last_byte_reg <= 1'b0;
            error_reg     <= 1'b0;
        end
        else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= byte_next;
                last_byte_reg <= last_next;
                error_reg     <= q_data.err;
                idx_reg       <= last_next ? '0 : idx_reg + 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`include "wide_char_to_utf8_encoder_top_assert.svh"

    `WCTU_ASSERT_ALWAYS(a_err_shape,
        !(out_valid_reg && error_reg) || (last_byte_reg && out_byte_reg == '0),
        "error transaction not a lone zero byte")
    `WCTU_ASSERT_ALWAYS(a_mid_entry_held, (idx_reg == '0) || q_valid,
        "entry left the queue mid encoding")

endmodule

// ===== rtl/wide_char_to_utf8_encoder_top.sv =====
// top level of the wide character to utf-8 encoder: apb register and wiring
// depends on wctu_pkg, wctu_front, wctu_queue, wctu_back
//
// input channel: in_valid/in_ready with code_unit (21 bits) and end_of_string.
// output channel: out_valid/out_ready with out_byte, last_byte and error; one
// transaction per utf-8 byte, last_byte marks the end of a code point; an
// error is a single transaction with out_byte zero and last_byte set.
// register 0 at address 0: pair_mode (reset 1); writing it drops a held
// high surrogate. pready is always high.
// a taken unit is written into the queue, then its bytes leave through the
// output register. throughput: one output byte per cycle while out_ready is
// high; a unit gives 1 to 4 bytes set by its encoded length, and the back
// end's byte counter is the limit. a held high surrogate gives no bytes.
// a two entry queue sits between classification and byte expansion, so new
// units are taken while earlier bytes drain or wait; in_ready drops only when
// that queue is full.
// reset empties the queue and output register, clears the held surrogate and
// sets utf16 mode; a stalled receiver holds the output byte steady.
module wide_char_to_utf8_encoder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wctu_pkg::PADDR_W-1:0]     paddr,
    input  logic [wctu_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wctu_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [wctu_pkg::UNIT_W-1:0]      code_unit,
    input  logic                             end_of_string,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [wctu_pkg::BYTE_W-1:0]      out_byte,
    output logic                             last_byte,
    output logic                             error
);
    import wctu_pkg::*;

    cfg_wr_t  cfg;
    logic     pair_mode;
    logic     q_full, q_push, q_pop, q_valid;
    q_entry_t q_in, q_head;

    // register access
    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite && (paddr == REG_ADDR_MODE);
    assign cfg.mode = pwdata[0];
    assign prdata   = (paddr == REG_ADDR_MODE) ? {{(APB_DATA_W-1){1'b0}}, pair_mode} : '0;

    wctu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .pair_mode     (pair_mode),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_unit     (code_unit),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    wctu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    wctu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .error     (error)
    );

endmodule
